// ----- hdl/mouse_packet_tracker_assert.svh -----
// Assertion macros for the tracker RTL, included by mouse_packet_tracker.sv.
// Define NO_ASSERTIONS to compile all checks away.
`ifndef MOUSE_PACKET_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on aclk outside reset
`define MPT_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mouse_packet_tracker check failed");

// Next-cycle implication, checked on aclk outside reset
`define MPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mouse_packet_tracker check failed");

`else

`define MPT_ASSERT(label, ante, cons)
`define MPT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/mpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    // Field and register widths
    localparam int BYTE_BITS   = 8;
    localparam int SCREEN_BITS = 12;
    localparam int COORD_BITS  = 12;

    // Cursor footprint in pixels
    localparam int CURSOR_W = 9;
    localparam int CURSOR_H = 9;

    // Signed working width for position and limit math
    localparam int CALC_W = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;

    // Bits of the first packet byte
    localparam int SYNC_BIT   = 3;
    localparam int LEFT_BIT   = 0;
    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;

    // APB register map
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(480);

    // Result stream packing: pos_x, pos_y, left, right, middle, zero fill
    localparam int RES_BITS   = 2 * COORD_BITS + 3;
    localparam int MDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // Position of the next byte within a packet
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                  middle_button;
        logic                  right_button;
        logic                  left_button;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
    } mpt_result_t;

    // Clamp a signed position to 0..screen - size - 1, limit capped at coordinate range
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CALC_W-1:0] pos,
        input logic [SCREEN_BITS-1:0]   screen,
        input int                       size
    );
        logic signed [CALC_W-1:0] limit;
        logic signed [CALC_W-1:0] coord_max;
        logic signed [CALC_W-1:0] res;
        limit     = $signed(CALC_W'(screen)) - $signed(CALC_W'(size)) - $signed(CALC_W'(1));
        coord_max = $signed(CALC_W'((1 << COORD_BITS) - 1));
        if (limit > coord_max) begin
            limit = coord_max;
        end
        if (pos < 0 || limit < 0) begin
            res = '0;
        end else if (pos > limit) begin
            res = limit;
        end else begin
            res = pos;
        end
        return res[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mpt_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpt_core import mpt_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,
    input  wire logic [BYTE_BITS-1:0]   rx_byte,
    input  wire logic [SCREEN_BITS-1:0] screen_width,
    input  wire logic [SCREEN_BITS-1:0] screen_height,
    output logic                        done,
    output mpt_result_t                 result
);

    phase_t                  phase_reg, phase_next;
    logic [BYTE_BITS-1:0]    first_reg;
    logic [BYTE_BITS-1:0]    second_reg;
    logic [COORD_BITS-1:0]   cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]   cursor_y_reg, cursor_y_next;
    logic signed [CALC_W-1:0] pos_x_raw;
    logic signed [CALC_W-1:0] pos_y_raw;

    // Advance the packet phase; drop unsynced first bytes
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            case (phase_reg)
                PH_FIRST:  phase_next = rx_byte[SYNC_BIT] ? PH_SECOND : PH_FIRST;
                PH_SECOND: phase_next = PH_THIRD;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    // Move the cursor on the closing byte: X adds byte 1, Y subtracts byte 2
    always_comb begin
        pos_x_raw = $signed(CALC_W'(cursor_x_reg))
                  + $signed({{(CALC_W-BYTE_BITS){second_reg[BYTE_BITS-1]}}, second_reg});
        pos_y_raw = $signed(CALC_W'(cursor_y_reg))
                  - $signed({{(CALC_W-BYTE_BITS){rx_byte[BYTE_BITS-1]}}, rx_byte});
        done          = 1'b0;
        cursor_x_next = clamp_coord(pos_x_raw, screen_width, CURSOR_W);
        cursor_y_next = clamp_coord(pos_y_raw, screen_height, CURSOR_H);
        case (phase_reg)
            PH_FIRST:  done = 1'b0;
            PH_SECOND: done = 1'b0;
            default:   done = step;
        endcase
        result.pos_x         = cursor_x_next;
        result.pos_y         = cursor_y_next;
        result.left_button   = first_reg[LEFT_BIT];
        result.right_button  = first_reg[RIGHT_BIT];
        result.middle_button = first_reg[MIDDLE_BIT];
    end

    // Hold packet state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            first_reg    <= '0;
            second_reg   <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            if (step && phase_reg == PH_FIRST && rx_byte[SYNC_BIT]) begin
                first_reg <= rx_byte;
            end
            if (step && phase_reg == PH_SECOND) begin
                second_reg <= rx_byte;
            end
            if (done) begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mouse_packet_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// PS/2 mouse packet tracker.
// s_ stream: one received mouse byte per request in s_tdata[7:0]. A byte with
//   bit 3 clear is dropped while a packet start is expected; three bytes make a
//   packet. The third byte yields one request on the m_ stream.
// m_ stream: m_tdata holds pos_x, pos_y, left, right and middle button; the
//   cursor is clamped to 0..screen size - 9 - 1 on each axis.
// APB: screen_width at 0x0, screen_height at 0x4, both 12 bits; write only
//   while no packet request is in flight.
// Throughput: one byte per cycle while the output register is empty or taken.
//   A byte is held in the input register, then the add-and-clamp logic fills
//   the output register, which drives m_tvalid for the closing byte.
// Stall: with m_tready low the output register holds, the input register
//   fills, and s_tready falls once both are occupied.
// Reset (aresetn low, synchronous): both stages empty, packet phase back to
//   first byte, cursor at 0,0, screen 640 by 480.
`include "mouse_packet_tracker_assert.svh"

module mouse_packet_tracker import mpt_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: [7:0] rx_byte
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_BITS-1:0]  s_tdata,
    // m_tdata: [11:0] pos_x, [23:12] pos_y, [24] left_button,
    //          [25] right_button, [26] middle_button, [31:27] zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [MDATA_BITS-1:0]      m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0]      prdata,
    output logic                       pready
);

    logic [SCREEN_BITS-1:0] screen_width_reg;
    logic [SCREEN_BITS-1:0] screen_height_reg;
    logic                   in_valid_reg;
    logic [BYTE_BITS-1:0]   in_byte_reg;
    logic                   out_valid_reg;
    mpt_result_t            out_data_reg;
    logic                   advance;
    logic                   step;
    logic                   core_done;
    mpt_result_t            core_result;
    logic                   reg_sel;
    logic                   x_checked;
    logic                   x_fits;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[SCREEN_BITS-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[SCREEN_BITS-1:0];
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SCREEN_WIDTH:  prdata = PDATA_BITS'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = PDATA_BITS'(screen_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Stage handshake: the output register frees when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    mpt_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .done          (core_done),
        .result        (core_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= core_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_done) begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MDATA_BITS'(out_data_reg);

    // Checks
    assign x_checked = m_tvalid && (screen_width_reg > SCREEN_BITS'(CURSOR_W));
    assign x_fits    = ({1'b0, out_data_reg.pos_x} + (SCREEN_BITS+1)'(CURSOR_W))
                     < {1'b0, screen_width_reg};

    `MPT_ASSERT(a_no_accept_when_full, in_valid_reg && !advance, !s_tready)
    `MPT_ASSERT(a_done_needs_byte, core_done, step)
    `MPT_ASSERT(a_x_in_screen, x_checked, x_fits)
    `MPT_ASSERT_NEXT(a_stall_holds_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire
